### hw/rtl/gr_pkg.sv
`timescale 1ns / 1ps

package gr_pkg;

  localparam int SCREEN_WIDTH_DEF  = 320;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int COORD_W    = 11;
  localparam int CODE_W     = 8;
  localparam int COLOR_W    = 8;
  localparam int ADDR_W     = 17;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;
  localparam int MASK_W     = GLYPH_COLS * GLYPH_ROWS;
  localparam int ROW_W      = $clog2(GLYPH_ROWS);
  // pixel coordinate: origin plus offset, one guard bit
  localparam int POS_W      = COORD_W + 1;
  // signed running address; covers origins of +-1024 on screens up to 1024 wide
  localparam int ACC_W      = 23;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);

  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_cols_t;

  typedef struct packed {
    logic        hit;
    glyph_cols_t cols;
  } glyph_t;

  typedef struct packed {
    logic [MASK_W-1:0]       mask;
    logic signed [ACC_W-1:0] base;
    logic [COLOR_W-1:0]      color;
  } gr_item_t;

  // column-major 5x7 font; bit r of a column is row r
  function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
    glyph_t g;
    g.hit = 1'b1;
    unique case (code)
      8'h41:   g.cols = {7'h7C, 7'h12, 7'h11, 7'h12, 7'h7C};
      8'h45:   g.cols = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
      8'h47:   g.cols = {7'h3A, 7'h49, 7'h49, 7'h41, 7'h3E};
      8'h4D:   g.cols = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      8'h4F:   g.cols = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      8'h50:   g.cols = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
      8'h4C:   g.cols = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
      8'h52:   g.cols = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
      8'h53:   g.cols = {7'h32, 7'h49, 7'h49, 7'h49, 7'h26};
      8'h56:   g.cols = {7'h07, 7'h38, 7'h40, 7'h38, 7'h07};
      8'h30:   g.cols = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
      8'h31:   g.cols = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
      8'h32:   g.cols = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
      8'h33:   g.cols = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
      8'h34:   g.cols = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
      8'h35:   g.cols = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
      8'h36:   g.cols = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      8'h37:   g.cols = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
      8'h38:   g.cols = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      8'h39:   g.cols = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
      8'h3A:   g.cols = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
      default: begin
        g.hit  = 1'b0;
        g.cols = '0;
      end
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/gr_front.sv
`timescale 1ns / 1ps

module gr_front #(
  parameter int SCREEN_WIDTH  = gr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [gr_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [gr_pkg::COORD_W-1:0] origin_y_i,
  input  logic [gr_pkg::CODE_W-1:0]         char_code_i,
  input  logic [gr_pkg::COLOR_W-1:0]        pixel_value_i,
  output logic                              push_o,
  output gr_pkg::gr_item_t                  item_o,
  input  logic                              full_i
);

  logic                              valid_q, valid_d;
  logic signed [gr_pkg::COORD_W-1:0] ox_q, oy_q;
  logic [gr_pkg::CODE_W-1:0]         code_q;
  logic [gr_pkg::COLOR_W-1:0]        color_q;

  gr_pkg::glyph_t                  glyph;
  logic [gr_pkg::GLYPH_COLS-1:0]   col_vis;
  logic [gr_pkg::GLYPH_ROWS-1:0]   row_vis;
  logic signed [gr_pkg::POS_W-1:0] px [gr_pkg::GLYPH_COLS];
  logic signed [gr_pkg::POS_W-1:0] py [gr_pkg::GLYPH_ROWS];
  logic [gr_pkg::MASK_W-1:0]       mask;
  logic                            done;
  logic                            accept;

  always_comb begin
    glyph = gr_pkg::glyph_lookup(code_q);
    for (int c = 0; c < gr_pkg::GLYPH_COLS; c++) begin
      px[c]      = gr_pkg::POS_W'(ox_q) + gr_pkg::POS_W'(c);
      col_vis[c] = (px[c] >= 0) && (px[c] < gr_pkg::POS_W'(SCREEN_WIDTH));
    end
    for (int r = 0; r < gr_pkg::GLYPH_ROWS; r++) begin
      py[r]      = gr_pkg::POS_W'(oy_q) + gr_pkg::POS_W'(r);
      row_vis[r] = (py[r] >= 0) && (py[r] < gr_pkg::POS_W'(SCREEN_HEIGHT));
    end
    for (int c = 0; c < gr_pkg::GLYPH_COLS; c++) begin
      for (int r = 0; r < gr_pkg::GLYPH_ROWS; r++) begin
        mask[c*gr_pkg::GLYPH_ROWS + r] = glyph.hit & glyph.cols[c][r] & col_vis[c] & row_vis[r];
      end
    end
  end

  assign item_o.mask  = mask;
  assign item_o.base  = gr_pkg::ACC_W'(oy_q) * gr_pkg::ACC_W'(SCREEN_WIDTH)
                      + gr_pkg::ACC_W'(ox_q);
  assign item_o.color = color_q;

  // nothing visible: drop without a queue slot
  assign push_o = valid_q && (mask != '0) && !full_i;
  assign done   = valid_q && ((mask == '0) || !full_i);
  assign busy   = valid_q && !done;
  assign accept = start && !busy;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (done) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      code_q  <= char_code_i;
      color_q <= pixel_value_i;
    end
  end

endmodule

### hw/rtl/gr_fifo.sv
`timescale 1ns / 1ps

module gr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hw/rtl/gr_back.sv
`timescale 1ns / 1ps

module gr_back #(
  parameter int SCREEN_WIDTH = gr_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  gr_pkg::gr_item_t           item_i,
  output logic                       pop_o,
  output logic                       pixel_valid_o,
  output logic [gr_pkg::ADDR_W-1:0]  pixel_address_o,
  output logic [gr_pkg::COLOR_W-1:0] pixel_color_o,
  output logic                       last_pixel_o
);

  localparam logic signed [gr_pkg::ACC_W-1:0] ROW_STEP = gr_pkg::ACC_W'(SCREEN_WIDTH);
  localparam logic signed [gr_pkg::ACC_W-1:0] COL_STEP =
    gr_pkg::ACC_W'(1 - (gr_pkg::GLYPH_ROWS - 1) * SCREEN_WIDTH);

  logic [gr_pkg::MASK_W-1:0]       mask_q, mask_d;
  logic signed [gr_pkg::ACC_W-1:0] addr_q, addr_d;
  logic [gr_pkg::ROW_W-1:0]        row_q, row_d;
  logic [gr_pkg::COLOR_W-1:0]      color_q, color_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_last_q, out_last_d;
  logic [gr_pkg::ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [gr_pkg::COLOR_W-1:0] out_color_q, out_color_d;

  logic rest_empty;

  assign rest_empty = (mask_q[gr_pkg::MASK_W-1:1] == '0);
  // load the next glyph in the cycle the current one scans its last set position, or when idle
  assign pop_o      = valid_i && rest_empty;

  always_comb begin
    mask_d  = mask_q;
    addr_d  = addr_q;
    row_d   = row_q;
    color_d = color_q;
    if (pop_o) begin
      mask_d  = item_i.mask;
      addr_d  = item_i.base;
      row_d   = '0;
      color_d = item_i.color;
    end else if (mask_q != '0) begin
      mask_d = mask_q >> 1;
      if (row_q == gr_pkg::ROW_LAST) begin
        row_d  = '0;
        addr_d = addr_q + COL_STEP;
      end else begin
        row_d  = row_q + 1'b1;
        addr_d = addr_q + ROW_STEP;
      end
    end
    out_valid_d = mask_q[0];
    out_last_d  = mask_q[0] && rest_empty;
    out_addr_d  = addr_q[gr_pkg::ADDR_W-1:0];
    out_color_d = color_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    row_q       <= row_d;
    color_q     <= color_d;
    out_addr_q  <= out_addr_d;
    out_color_q <= out_color_d;
  end

  assign pixel_valid_o   = out_valid_q;
  assign pixel_address_o = out_addr_q;
  assign pixel_color_o   = out_color_q;
  assign last_pixel_o    = out_last_q;

endmodule

### hw/rtl/glyph_rasterizer_5x7.sv
// A start beat reaches its first write through classify, queue, scan and output reg.
// Throughput: the scanner walks the 35-position glyph mask one position a cycle, stopping
//   after each character's last visible pixel.
// Front accepts one request a cycle while the 2-entry queue has room; busy shows otherwise.
// Reset (async, active low) clears the front, queue and scanner; writes cannot be stalled.
`timescale 1ns / 1ps

module glyph_rasterizer_5x7 #(
  parameter int SCREEN_WIDTH  = gr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gr_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = gr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [gr_pkg::COORD_W-1:0] origin_x_i,
  input  logic signed [gr_pkg::COORD_W-1:0] origin_y_i,
  input  logic [gr_pkg::CODE_W-1:0]         char_code_i,
  input  logic [gr_pkg::COLOR_W-1:0]        pixel_value_i,
  output logic                              pixel_valid_o,
  output logic [gr_pkg::ADDR_W-1:0]         pixel_address_o,
  output logic [gr_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic                              last_pixel_o
);

  gr_pkg::gr_item_t push_item, pop_item;
  logic             push, full, pop, q_valid;

  gr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .char_code_i  (char_code_i),
    .pixel_value_i(pixel_value_i),
    .push_o       (push),
    .item_o       (push_item),
    .full_i       (full)
  );

  gr_fifo #(
    .WIDTH($bits(gr_pkg::gr_item_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (pop_item)
  );

  gr_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (pop_item),
    .pop_o          (pop),
    .pixel_valid_o  (pixel_valid_o),
    .pixel_address_o(pixel_address_o),
    .pixel_color_o  (pixel_color_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

### hw/rtl/gr_checker.sv
`timescale 1ns / 1ps

module gr_checker #(
  parameter int SCREEN_WIDTH  = gr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = gr_pkg::SCREEN_HEIGHT_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       pixel_valid_o,
  input logic [gr_pkg::ADDR_W-1:0]  pixel_address_o,
  input logic                       last_pixel_o
);

  localparam logic [31:0] PIXELS = 32'(SCREEN_WIDTH * SCREEN_HEIGHT);

  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_pixel_o |-> pixel_valid_o)
    else $error("last flag without a write beat");

  a_addr_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_valid_o |-> (32'(pixel_address_o) < PIXELS))
    else $error("write beat outside the screen");

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !pixel_valid_o)
    else $error("write beat right after reset");

endmodule

bind glyph_rasterizer_5x7 gr_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_gr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pixel_valid_o  (pixel_valid_o),
  .pixel_address_o(pixel_address_o),
  .last_pixel_o   (last_pixel_o)
);
